[sv/tcce_pkg.sv]
// ----------------------------------------------------------------------------
// tcce_pkg
// Shared types and constants for the text console character engine.
// ----------------------------------------------------------------------------
`default_nettype none

package tcce_pkg;

  typedef enum logic [1:0] {
    OP_PRINT  = 2'd0,
    OP_SETPOS = 2'd1,
    OP_READ   = 2'd2,
    OP_CLEAR  = 2'd3
  } tcce_op_e;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_RDWAIT,
    ST_SCROLL,
    ST_FILL,
    ST_CLEAR,
    ST_DONE
  } tcce_state_e;

  // configuration register indexes
  localparam logic [7:0] CFG_ATTRIBUTE = 8'd0;
  localparam logic [7:0] CFG_CURSOR_EN = 8'd1;

  localparam logic [7:0] ATTR_RESET = 8'h07;

  // control characters and the space
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam int TAB_STOP = 8;
  localparam int PARK_POS = 255;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] char_code;
    logic [7:0] pos_x;
    logic [7:0] pos_y;
  } tcce_in_t;

  typedef struct packed {
    logic [6:0]  cur_col;
    logic [4:0]  cur_row;
    logic [15:0] hw_cursor_addr;
    logic [15:0] cell_data;
    logic        scrolled;
  } tcce_out_t;

endpackage

`default_nettype wire

[sv/tcce_cell_ram.sv]
// ----------------------------------------------------------------------------
// tcce_cell_ram
// Character cell store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tcce_cell_ram #(
  parameter int Depth = 2000,
  parameter int AddrW = 11
) (
  input  wire logic             clk_i,
  input  wire logic             wr_en_i,
  input  wire logic [AddrW-1:0] wr_addr_i,
  input  wire logic [15:0]      wr_data_i,
  input  wire logic             rd_en_i,
  input  wire logic [AddrW-1:0] rd_addr_i,
  output logic      [15:0]      rd_data_o
);

  logic [15:0] mem [Depth];
  logic [15:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

[sv/text_console_char_engine_core.sv]
// Set cursor and non-scrolling print pass through EXEC and DONE; read cell adds
//   RDWAIT; clear sweeps all cells in CLEAR; a scrolling print adds SCROLL and FILL.
// Throughput: one operation at a time; the scroll and clear sweeps through the
//   single write port of the cell store set the rate, one cell per cycle.
// Reset: cursor to 0,0, attribute 0x07, cursor shown; then a clearing pass over
//   all COLS*ROWS cells zeroes the store while no word is accepted.
// ----------------------------------------------------------------------------
// text_console_char_engine_core
// Teletype text console over a COLS x ROWS store of 16-bit character cells.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_char_engine_core #(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire tcce_pkg::tcce_in_t  in_word_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output tcce_pkg::tcce_out_t      out_word_o,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [7:0]          cfg_index_i,
  input  wire logic [7:0]          cfg_data_i
);

  localparam int Cells = COLS * ROWS;
  localparam int AddrW = $clog2(Cells);
  localparam int ColW  = $clog2(COLS);
  localparam int RowW  = $clog2(ROWS);
  localparam logic [15:0] ParkAddr =
    16'(tcce_pkg::PARK_POS * COLS + tcce_pkg::PARK_POS);
  localparam logic [AddrW-1:0] LastCell  = AddrW'(Cells - 1);
  localparam logic [AddrW-1:0] RowOne    = AddrW'(COLS);
  localparam logic [AddrW-1:0] BottomRow = AddrW'((ROWS - 1) * COLS);

  tcce_pkg::tcce_state_e state_q, state_d;
  tcce_pkg::tcce_op_e    op_q;
  logic [7:0]            ch_q;
  logic [ColW-1:0]       px_q;
  logic [RowW-1:0]       py_q;
  logic [ColW-1:0]       col_q, col_d;
  logic [RowW-1:0]       row_q, row_d;
  logic [AddrW-1:0]      cnt_q, cnt_d;
  logic                  scr_q, scr_d;
  logic [15:0]           cell_q, cell_d;
  logic [7:0]            attr_q;
  logic                  cur_en_q;
  logic                  mv_valid_q;
  logic [AddrW-1:0]      mv_addr_q;
  logic                  out_valid_q;
  tcce_pkg::tcce_out_t   out_q;

  logic                  accept;
  logic                  out_load;
  logic                  wr_en;
  logic [AddrW-1:0]      wr_addr;
  logic [15:0]           wr_data;
  logic                  rd_en;
  logic [AddrW-1:0]      rd_addr;
  logic [15:0]           rd_data;
  logic [15:0]           blank;
  logic [RowW-1:0]       mul_row;
  logic [ColW-1:0]       mul_col;
  logic [15:0]           lin_addr;
  logic [8:0]            tab_col;
  logic                  rd_sel;

  assign accept      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign blank       = {attr_q, tcce_pkg::CH_SPACE};

  // one shared multiplier: cell address for read/print, hw cursor at the end
  assign rd_sel   = (state_q == tcce_pkg::ST_EXEC) && (op_q == tcce_pkg::OP_READ);
  assign mul_row  = rd_sel ? py_q : row_q;
  assign mul_col  = rd_sel ? px_q : col_q;
  assign lin_addr = 16'(int'(mul_row) * COLS + int'(mul_col));

  assign tab_col = (9'(col_q) + 9'(tcce_pkg::TAB_STOP)) & ~9'(tcce_pkg::TAB_STOP - 1);

  tcce_cell_ram #(
    .Depth (Cells),
    .AddrW (AddrW)
  ) u_cell_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    col_d      = col_q;
    row_d      = row_q;
    scr_d      = scr_q;
    cell_d     = cell_q;
    in_stall_o = 1'b1;
    out_load   = 1'b0;
    wr_en      = 1'b0;
    wr_addr    = cnt_q;
    wr_data    = blank;
    rd_en      = 1'b0;
    rd_addr    = cnt_q;
    case (state_q)
      tcce_pkg::ST_INIT: begin
        wr_en   = 1'b1;
        wr_data = '0;
        cnt_d   = cnt_q + 1'b1;
        if (cnt_q == LastCell) begin
          state_d = tcce_pkg::ST_IDLE;
        end
      end
      tcce_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          state_d = tcce_pkg::ST_EXEC;
        end
      end
      tcce_pkg::ST_EXEC: begin
        scr_d   = 1'b0;
        cell_d  = '0;
        state_d = tcce_pkg::ST_DONE;
        case (op_q)
          tcce_pkg::OP_PRINT: begin
            case (ch_q)
              tcce_pkg::CH_LF: begin
                col_d = '0;
                if (int'(row_q) + 1 >= ROWS) begin
                  scr_d   = 1'b1;
                  cnt_d   = RowOne;
                  state_d = tcce_pkg::ST_SCROLL;
                end else begin
                  row_d = row_q + 1'b1;
                end
              end
              tcce_pkg::CH_CR: begin
                col_d = '0;
              end
              tcce_pkg::CH_TAB: begin
                if (int'(tab_col) >= COLS) begin
                  col_d = '0;
                  if (int'(row_q) + 1 >= ROWS) begin
                    scr_d   = 1'b1;
                    cnt_d   = RowOne;
                    state_d = tcce_pkg::ST_SCROLL;
                  end else begin
                    row_d = row_q + 1'b1;
                  end
                end else begin
                  col_d = ColW'(tab_col);
                end
              end
              tcce_pkg::CH_BS: begin
                if (col_q != '0) begin
                  col_d = col_q - 1'b1;
                end
              end
              default: begin
                wr_en   = 1'b1;
                wr_addr = AddrW'(lin_addr);
                wr_data = {attr_q, ch_q};
                if (int'(col_q) + 1 >= COLS) begin
                  col_d = '0;
                  if (int'(row_q) + 1 >= ROWS) begin
                    scr_d   = 1'b1;
                    cnt_d   = RowOne;
                    state_d = tcce_pkg::ST_SCROLL;
                  end else begin
                    row_d = row_q + 1'b1;
                  end
                end else begin
                  col_d = col_q + 1'b1;
                end
              end
            endcase
          end
          tcce_pkg::OP_SETPOS: begin
            col_d = px_q;
            row_d = py_q;
          end
          tcce_pkg::OP_READ: begin
            rd_en   = 1'b1;
            rd_addr = AddrW'(lin_addr);
            state_d = tcce_pkg::ST_RDWAIT;
          end
          tcce_pkg::OP_CLEAR: begin
            cnt_d   = '0;
            state_d = tcce_pkg::ST_CLEAR;
          end
          default: begin
            state_d = tcce_pkg::ST_DONE;
          end
        endcase
      end
      tcce_pkg::ST_RDWAIT: begin
        cell_d  = rd_data;
        state_d = tcce_pkg::ST_DONE;
      end
      tcce_pkg::ST_SCROLL: begin
        // read row below, write it one row up on the next cycle
        rd_en   = 1'b1;
        wr_en   = mv_valid_q;
        wr_addr = mv_addr_q;
        wr_data = rd_data;
        if (cnt_q == LastCell) begin
          cnt_d   = BottomRow;
          state_d = tcce_pkg::ST_FILL;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      tcce_pkg::ST_FILL: begin
        if (mv_valid_q) begin
          // drain the last moved cell before filling
          wr_en   = 1'b1;
          wr_addr = mv_addr_q;
          wr_data = rd_data;
        end else begin
          wr_en = 1'b1;
          cnt_d = cnt_q + 1'b1;
          if (cnt_q == LastCell) begin
            state_d = tcce_pkg::ST_DONE;
          end
        end
      end
      tcce_pkg::ST_CLEAR: begin
        wr_en = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == LastCell) begin
          state_d = tcce_pkg::ST_DONE;
        end
      end
      tcce_pkg::ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = tcce_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = tcce_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tcce_pkg::ST_INIT;
      cnt_q       <= '0;
      col_q       <= '0;
      row_q       <= '0;
      scr_q       <= 1'b0;
      attr_q      <= tcce_pkg::ATTR_RESET;
      cur_en_q    <= 1'b1;
      mv_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      col_q      <= col_d;
      row_q      <= row_d;
      scr_q      <= scr_d;
      mv_valid_q <= (state_q == tcce_pkg::ST_SCROLL);
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == tcce_pkg::CFG_ATTRIBUTE) begin
          attr_q <= cfg_data_i;
        end else if (cfg_index_i == tcce_pkg::CFG_CURSOR_EN) begin
          cur_en_q <= cfg_data_i[0];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cell_q    <= cell_d;
    mv_addr_q <= cnt_q - RowOne;
    if (accept) begin
      op_q <= tcce_pkg::tcce_op_e'(in_word_i.op);
      ch_q <= in_word_i.char_code;
      px_q <= (int'(in_word_i.pos_x) >= COLS) ? ColW'(COLS - 1) : ColW'(in_word_i.pos_x);
      py_q <= (int'(in_word_i.pos_y) >= ROWS) ? RowW'(ROWS - 1) : RowW'(in_word_i.pos_y);
    end
    if (out_load) begin
      out_q.cur_col        <= 7'(col_q);
      out_q.cur_row        <= 5'(row_q);
      out_q.hw_cursor_addr <= cur_en_q ? lin_addr : ParkAddr;
      out_q.cell_data      <= cell_q;
      out_q.scrolled       <= scr_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  a_col_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(col_q) < COLS)
    else $error("cursor column out of range");

  a_row_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(row_q) < ROWS)
    else $error("cursor row out of range");

  a_scroll_pos : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tcce_pkg::ST_DONE && scr_q) |->
      (col_q == '0 && int'(row_q) == ROWS - 1))
    else $error("scroll finished with cursor off the bottom line start");

  a_no_idle_write : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tcce_pkg::ST_IDLE || state_q == tcce_pkg::ST_DONE) |-> !wr_en)
    else $error("cell store written outside an operation");

  a_move_in_order : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mv_valid_q |-> (state_q == tcce_pkg::ST_SCROLL || state_q == tcce_pkg::ST_FILL))
    else $error("pending row move lost");

endmodule

`default_nettype wire
